// File: src/speq_pkg.sv
`timescale 1ns / 1ps

package speq_pkg;

    localparam int PRIO_W = 8;
    localparam int OCC_W  = 5;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic push;
        logic pop;
    } cell_cmd_t;

endpackage

// File: src/speq_cell.sv
`timescale 1ns / 1ps

// One slot of the sorted row. Takes the new word, its left neighbor's word
// (insert shifts right) or its right neighbor's word (pop shifts left).
module speq_cell #(
    parameter int TAG_WIDTH = 16
) (
    input  logic                          clk,
    input  speq_pkg::cell_cmd_t           cmd,
    input  logic                          occupied,
    input  logic [speq_pkg::PRIO_W-1:0]   new_prio,
    input  logic [TAG_WIDTH-1:0]          new_tag,
    input  logic                          prev_want,
    input  logic [speq_pkg::PRIO_W-1:0]   prev_prio,
    input  logic [TAG_WIDTH-1:0]          prev_tag,
    input  logic [speq_pkg::PRIO_W-1:0]   next_prio,
    input  logic [TAG_WIDTH-1:0]          next_tag,
    output logic                          want,
    output logic [speq_pkg::PRIO_W-1:0]   prio,
    output logic [TAG_WIDTH-1:0]          tag
);

    logic [speq_pkg::PRIO_W-1:0] prio_reg;
    logic [speq_pkg::PRIO_W-1:0] prio_next;
    logic [TAG_WIDTH-1:0]        tag_reg;
    logic [TAG_WIDTH-1:0]        tag_next;

    // at or past the insert point: empty, or strictly lower priority
    assign want = !occupied || (prio_reg < new_prio);
    assign prio = prio_reg;
    assign tag  = tag_reg;

    always_comb
    begin
        prio_next = prio_reg;
        tag_next  = tag_reg;
        if (cmd.push && want)
        begin
            if (prev_want)
            begin
                prio_next = prev_prio;
                tag_next  = prev_tag;
            end
            else
            begin
                prio_next = new_prio;
                tag_next  = new_tag;
            end
        end
        else if (cmd.pop)
        begin
            prio_next = next_prio;
            tag_next  = next_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

endmodule

// File: src/stable_priority_event_queue_core.sv
`timescale 1ns / 1ps

// Stable priority event queue. One push or pop word is taken on every clock
// edge where start is high; busy is never raised, so the block takes a word
// in every cycle. The result of each word appears on the result ports in the
// following cycle, marked by done for exactly one cycle; the receiver cannot
// stall, so it must capture every done cycle. The rate is one word per
// cycle: the whole row of QUEUE_DEPTH cells compares the pushed priority
// in parallel and shifts in one step. Entries leave in descending priority,
// first-in first-out within one priority. A push into a full queue returns
// status full and changes nothing; a pop of an empty queue returns status
// empty with pop_valid, pop_priority and pop_tag at zero.
module stable_priority_event_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_WIDTH   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [speq_pkg::PRIO_W-1:0]   priority_req,
    input  logic [TAG_WIDTH-1:0]          event_tag,
    output logic                          done,
    output logic                          pop_valid,
    output logic [speq_pkg::PRIO_W-1:0]   pop_priority,
    output logic [TAG_WIDTH-1:0]          pop_tag,
    output logic [1:0]                    status,
    output logic [speq_pkg::OCC_W-1:0]    occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // occupancy counter: cell i holds a live entry when i < count
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             accept;
    logic             full;
    logic             empty;
    speq_pkg::cell_cmd_t cmd;

    // cell row taps
    logic                        cell_want [QUEUE_DEPTH];
    logic [speq_pkg::PRIO_W-1:0] cell_prio [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0]        cell_tag  [QUEUE_DEPTH];

    // result register
    logic                        done_reg;
    logic                        done_next;
    logic                        pop_valid_reg;
    logic                        pop_valid_next;
    logic [speq_pkg::PRIO_W-1:0] pop_priority_reg;
    logic [speq_pkg::PRIO_W-1:0] pop_priority_next;
    logic [TAG_WIDTH-1:0]        pop_tag_reg;
    logic [TAG_WIDTH-1:0]        pop_tag_next;
    logic [1:0]                  status_reg;
    logic [1:0]                  status_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);

    assign cmd.push = accept && (mode == speq_pkg::MODE_PUSH) && !full;
    assign cmd.pop  = accept && (mode == speq_pkg::MODE_POP) && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic                        prev_want;
            logic [speq_pkg::PRIO_W-1:0] prev_prio;
            logic [TAG_WIDTH-1:0]        prev_tag;
            logic [speq_pkg::PRIO_W-1:0] next_prio;
            logic [TAG_WIDTH-1:0]        next_tag;

            if (gi == 0)
            begin : g_head
                // head: nothing to its left, new word lands here if it wants
                assign prev_want = 1'b0;
                assign prev_prio = '0;
                assign prev_tag  = '0;
            end
            else
            begin : g_body
                assign prev_want = cell_want[gi-1];
                assign prev_prio = cell_prio[gi-1];
                assign prev_tag  = cell_tag[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                // tail slot goes dead after a pop; contents do not matter
                assign next_prio = cell_prio[gi];
                assign next_tag  = cell_tag[gi];
            end
            else
            begin : g_mid
                assign next_prio = cell_prio[gi+1];
                assign next_tag  = cell_tag[gi+1];
            end

            speq_cell #(
                .TAG_WIDTH (TAG_WIDTH)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .occupied  (CNT_W'(gi) < count_reg),
                .new_prio  (priority_req),
                .new_tag   (event_tag),
                .prev_want (prev_want),
                .prev_prio (prev_prio),
                .prev_tag  (prev_tag),
                .next_prio (next_prio),
                .next_tag  (next_tag),
                .want      (cell_want[gi]),
                .prio      (cell_prio[gi]),
                .tag       (cell_tag[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        done_next         = accept;
        pop_valid_next    = cmd.pop;
        pop_priority_next = '0;
        pop_tag_next      = '0;
        status_next       = speq_pkg::STATUS_OK;
        if (cmd.pop)
        begin
            // head cell holds the entry being removed
            pop_priority_next = cell_prio[0];
            pop_tag_next      = cell_tag[0];
        end
        if (mode == speq_pkg::MODE_PUSH && full)
        begin
            status_next = speq_pkg::STATUS_FULL;
        end
        else if (mode == speq_pkg::MODE_POP && empty)
        begin
            status_next = speq_pkg::STATUS_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload: loaded with every accepted word, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop_valid_reg    <= pop_valid_next;
            pop_priority_reg <= pop_priority_next;
            pop_tag_reg      <= pop_tag_next;
            status_reg       <= status_next;
        end
    end

    assign done         = done_reg;
    assign pop_valid    = pop_valid_reg;
    assign pop_priority = pop_priority_reg;
    assign pop_tag      = pop_tag_reg;
    assign status       = status_reg;
    assign occupancy    = speq_pkg::OCC_W'(count_reg);

endmodule

// File: src/speq_checker.sv
`timescale 1ns / 1ps

module speq_checker #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_WIDTH   = 16
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic                        pop_valid,
    input logic [speq_pkg::PRIO_W-1:0] pop_priority,
    input logic [TAG_WIDTH-1:0]        pop_tag,
    input logic [1:0]                  status,
    input logic [speq_pkg::OCC_W-1:0]  occupancy
);

    // every accepted word yields exactly one result, in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && start && !busy |=> done)
        else $error("accepted word gave no result");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without accepted word");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == speq_pkg::STATUS_FULL |->
            occupancy == speq_pkg::OCC_W'(QUEUE_DEPTH) && !pop_valid)
        else $error("full refusal with wrong occupancy");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == speq_pkg::STATUS_EMPTY |->
            occupancy == '0 && !pop_valid && pop_priority == '0 && pop_tag == '0)
        else $error("empty pop returned data");

    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && pop_valid |-> status == speq_pkg::STATUS_OK)
        else $error("popped entry with error status");

endmodule

bind stable_priority_event_queue_core speq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH)
) u_speq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .pop_valid    (pop_valid),
    .pop_priority (pop_priority),
    .pop_tag      (pop_tag),
    .status       (status),
    .occupancy    (occupancy)
);

// File: verif/tb_stable_priority_event_queue_core.sv
`timescale 1ns / 1ps

// Self-checking bench for the stable priority event queue.
// A directed opening drives the corner cases, then a long random stream of
// push and pop words. Each accepted word goes through a local sorted-insert
// model, and its expected result is queued. Every done cycle is checked
// against the oldest expected result.
module tb_stable_priority_event_queue_core;

    localparam int DEPTH        = 16;
    localparam int TAGW         = 16;
    localparam int RANDOM_WORDS = 1850;
    localparam int CALM_TAIL    = 200;   // last words are sent back to back
    localparam int MAX_REPORTS  = 10;

    // One command word as the sender presents it
    typedef struct packed {
        logic                        mode;
        logic [speq_pkg::PRIO_W-1:0] prio;
        logic [TAGW-1:0]             tag;
    } queue_word_t;

    // One result word as the block reports it
    typedef struct packed {
        logic                        pop_valid;
        logic [speq_pkg::PRIO_W-1:0] prio;
        logic [TAGW-1:0]             tag;
        logic [1:0]                  status;
        logic [speq_pkg::OCC_W-1:0]  occ;
    } queue_result_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        start        = 1'b0;
    logic                        mode         = speq_pkg::MODE_PUSH;
    logic [speq_pkg::PRIO_W-1:0] priority_req = '0;
    logic [TAGW-1:0]             event_tag    = '0;
    logic                        busy;
    logic                        done;
    logic                        pop_valid;
    logic [speq_pkg::PRIO_W-1:0] pop_priority;
    logic [TAGW-1:0]             pop_tag;
    logic [1:0]                  status;
    logic [speq_pkg::OCC_W-1:0]  occupancy;

    // Words waiting to be sent, and results waiting to arrive
    queue_word_t   word_backlog[$];
    queue_result_t pending_results[$];

    // Local copy of the queue contents; index 0 is the head
    logic [speq_pkg::PRIO_W-1:0] held_prio[DEPTH];
    logic [TAGW-1:0]             held_tag[DEPTH];
    int                          held_count = 0;

    int total_words    = 0;
    int presented_count = 0;
    int accepted_count = 0;
    int idle_left      = 0;
    int mismatches     = 0;

    // Run statistics for the summary
    int push_words   = 0;
    int pop_words    = 0;
    int full_refused = 0;
    int empty_pops   = 0;
    int peak_occ     = 0;

    stable_priority_event_queue_core #(
        .QUEUE_DEPTH (DEPTH),
        .TAG_WIDTH   (TAGW)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .priority_req (priority_req),
        .event_tag    (event_tag),
        .done         (done),
        .pop_valid    (pop_valid),
        .pop_priority (pop_priority),
        .pop_tag      (pop_tag),
        .status       (status),
        .occupancy    (occupancy)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Sorted insert / head removal on the local queue copy.
    // A push lands ahead of the first entry with strictly lower priority,
    // so equal priorities stay first-in first-out.
    function automatic queue_result_t queue_word_effect(queue_word_t w);
        queue_result_t r;
        int            pos;
        r = '0;
        if (w.mode == speq_pkg::MODE_PUSH)
        begin
            if (held_count >= DEPTH)
                r.status = speq_pkg::STATUS_FULL;
            else
            begin
                pos = held_count;
                for (int i = 0; i < held_count; i++)
                    if (pos == held_count && held_prio[i] < w.prio)
                        pos = i;
                for (int i = held_count; i > pos; i--)
                begin
                    held_prio[i] = held_prio[i-1];
                    held_tag[i]  = held_tag[i-1];
                end
                held_prio[pos] = w.prio;
                held_tag[pos]  = w.tag;
                held_count++;
            end
        end
        else
        begin
            if (held_count == 0)
                r.status = speq_pkg::STATUS_EMPTY;
            else
            begin
                r.pop_valid = 1'b1;
                r.prio      = held_prio[0];
                r.tag       = held_tag[0];
                for (int i = 1; i < held_count; i++)
                begin
                    held_prio[i-1] = held_prio[i];
                    held_tag[i-1]  = held_tag[i];
                end
                held_count--;
            end
        end
        r.occ = speq_pkg::OCC_W'(held_count);
        return r;
    endfunction

    task automatic note_failure(string what, queue_result_t exp);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display({"%0t %s: exp valid=%0b prio=%0d tag=%h status=%0d occ=%0d",
                      " | got valid=%0b prio=%0d tag=%h status=%0d occ=%0d"},
                     $realtime, what, exp.pop_valid, exp.prio, exp.tag, exp.status,
                     exp.occ, pop_valid, pop_priority, pop_tag, status, occupancy);
    endtask

    // Driver: changes inputs on the falling edge. A word stays on the bus
    // until the monitor has seen it accepted; idle bursts go between words.
    always @(negedge clk)
    begin
        queue_word_t next_word;
        if (rst_n && !(start && presented_count > accepted_count))
        begin
            if (idle_left == 0 && word_backlog.size() > CALM_TAIL
                && ((presented_count / 150) % 3 != 2) && $urandom_range(0, 3) == 0)
                idle_left = $urandom_range(1, 9);
            if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (word_backlog.size() > 0)
            begin
                next_word = word_backlog.pop_front();
                mode         <= next_word.mode;
                priority_req <= next_word.prio;
                event_tag    <= next_word.tag;
                start        <= 1'b1;
                presented_count++;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: on the rising edge, first check a result that ends this
    // cycle, then take the word accepted at this edge into the model.
    always @(posedge clk)
    begin
        queue_word_t   taken;
        queue_result_t exp;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                    note_failure("result with none expected", '0);
                else
                begin
                    exp = pending_results.pop_front();
                    if (pop_valid !== exp.pop_valid || pop_priority !== exp.prio
                        || pop_tag !== exp.tag || status !== exp.status
                        || occupancy !== exp.occ)
                        note_failure("result mismatch", exp);
                end
            end
            if (start && !busy)
            begin
                taken = '{mode: mode, prio: priority_req, tag: event_tag};
                exp   = queue_word_effect(taken);
                pending_results.push_back(exp);
                accepted_count++;
                if (taken.mode == speq_pkg::MODE_PUSH)
                    push_words++;
                else
                    pop_words++;
                if (exp.status == speq_pkg::STATUS_FULL)
                    full_refused++;
                if (exp.status == speq_pkg::STATUS_EMPTY)
                    empty_pops++;
                if (held_count > peak_occ)
                    peak_occ = held_count;
            end
        end
    end

    task automatic add_word(logic m, logic [speq_pkg::PRIO_W-1:0] p, logic [TAGW-1:0] t);
        word_backlog.push_back('{mode: m, prio: p, tag: t});
    endtask

    // Random priority: full range, four coarse levels including both
    // extremes, or a narrow band that piles up ties.
    function automatic logic [speq_pkg::PRIO_W-1:0] pick_prio();
        case ($urandom_range(0, 2))
            0:       return speq_pkg::PRIO_W'($urandom_range(0, 255));
            1:       return speq_pkg::PRIO_W'($urandom_range(0, 3) * 85);
            default: return speq_pkg::PRIO_W'($urandom_range(100, 103));
        endcase
    endfunction

    task automatic build_stimulus();
        int push_pct;
        // pop on an empty queue, with junk on the push fields
        add_word(speq_pkg::MODE_POP, 8'hFF, 16'hFFFF);
        // extremes, ties at the top, middle and bottom
        add_word(speq_pkg::MODE_PUSH, 8'd255, 16'h0000);
        add_word(speq_pkg::MODE_PUSH, 8'd0,   16'hFFFF);
        add_word(speq_pkg::MODE_PUSH, 8'd128, 16'h0001);
        add_word(speq_pkg::MODE_PUSH, 8'd128, 16'h0002);
        add_word(speq_pkg::MODE_PUSH, 8'd255, 16'hAAAA);
        add_word(speq_pkg::MODE_PUSH, 8'd0,   16'h5555);
        for (int k = 0; k < 10; k++)
            add_word(speq_pkg::MODE_PUSH, speq_pkg::PRIO_W'(k * 28), TAGW'(k + 3));
        // queue is full now: both pushes get refused
        add_word(speq_pkg::MODE_PUSH, 8'd200, 16'hBEEF);
        add_word(speq_pkg::MODE_PUSH, 8'd0,   16'h0F0F);
        add_word(speq_pkg::MODE_POP, 8'h00, 16'h0000);
        add_word(speq_pkg::MODE_POP, 8'h00, 16'h0000);
        add_word(speq_pkg::MODE_POP, 8'h5A, 16'hA5A5);
        add_word(speq_pkg::MODE_PUSH, 8'd128, 16'h1234);

        // random phases, each leaning toward filling or draining the queue
        push_pct = 50;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 60 == 0)
                case ($urandom_range(0, 3))
                    0:       push_pct = 15;
                    1:       push_pct = 45;
                    2:       push_pct = 55;
                    default: push_pct = 85;
                endcase
            add_word(($urandom_range(1, 100) <= push_pct) ? speq_pkg::MODE_PUSH
                                                          : speq_pkg::MODE_POP,
                     pick_prio(), TAGW'($urandom_range(0, 65535)));
        end
        total_words = word_backlog.size();
    endtask

    initial
    begin
        int waited;
        build_stimulus();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_count < total_words)
            @(posedge clk);

        // drain: each result comes back in the next cycle, so a short wait is plenty
        waited = 0;
        while (pending_results.size() > 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        #1;
        if (pending_results.size() > 0)
        begin
            mismatches += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end

        $display("ran %0d words: %0d pushes (%0d refused full), %0d pops (%0d on empty)",
                 accepted_count, push_words, full_refused, pop_words, empty_pops);
        $display("peak occupancy %0d of %0d, failures %0d", peak_occ, DEPTH, mismatches);
        if (mismatches == 0)
            $display("stable_priority_event_queue_core: match");
        else
            $display("stable_priority_event_queue_core: mismatch");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout waiting for the queue");
        $display("stable_priority_event_queue_core: mismatch");
        $finish;
    end

endmodule
